// ===== rtl/sitad_pkg.sv =====
// ----------------------------------------------------------------------------
// sitad_pkg
// Shared types and constants for the signed integer to ASCII decimal block.
// ----------------------------------------------------------------------------
`default_nettype none

package sitad_pkg;

	localparam int unsigned NUM_DIGITS    = 10;
	localparam int unsigned BCD_W         = NUM_DIGITS * 4;
	localparam int unsigned BIN_W         = 32;
	localparam int unsigned BITS_PER_STEP = 4;
	localparam int unsigned NUM_STEPS     = BIN_W / BITS_PER_STEP;
	localparam int unsigned STEP_CNT_W    = $clog2(NUM_STEPS);
	localparam int unsigned DIG_CNT_W     = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] ASCII_ZERO  = 8'd48;
	localparam logic [7:0] ASCII_NINE  = 8'd57;
	localparam logic [7:0] ASCII_MINUS = 8'd45;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_SKIP,
		S_SIGN,
		S_DIGIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic shift;
		logic sign;
	} cmd_t;

	typedef struct packed {
		logic step_last;
		logic top_zero;
		logic dig_one;
		logic negative;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/signed_int_to_ascii_decimal.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_ascii_decimal
// Renders a signed 32-bit integer as ASCII decimal text, one character per
// item, most significant digit first, with an optional leading minus sign.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  input    | in_valid / in_stall  | number[31:0] (signed)
//  output   | out_valid / out_stall| char_code[7:0], last_char
//
//  per number: a load, the conversion at 4 bits per cycle, dropping the leading
//  zeros of the magnitude and leaving that state, then one character at a time,
//  each held while the output stalls.
//  the next number is taken only once the last character has left.
//  reset clears the sequencer only; no state is kept between numbers.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_ascii_decimal
	import sitad_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [BIN_W-1:0] number,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic [7:0]                   char_code,
	output logic                         last_char
);

	cmd_t    cmd;
	status_t status;

	sitad_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	sitad_datapath u_datapath (
		.clk       (clk),
		.number    (number),
		.cmd       (cmd),
		.status    (status),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

`default_nettype wire

// ===== rtl/sitad_datapath.sv =====
// ----------------------------------------------------------------------------
// sitad_datapath
// Magnitude, shift-add-3 binary to BCD converter and character shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module sitad_datapath
	import sitad_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic signed [BIN_W-1:0] number,
	input  wire cmd_t                    cmd,
	output status_t                      status,
	output logic [7:0]                   char_code,
	output logic                         last_char
);

	logic [BIN_W-1:0]      mag_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [DIG_CNT_W-1:0]  dig_q;
	logic                  neg_q;

	logic [BIN_W-1:0] mag_in;
	logic [BCD_W-1:0] bcd_nx;
	logic [BIN_W-1:0] mag_nx;
	logic [3:0]       top;

	assign mag_in = number[BIN_W-1] ? BIN_W'(~number + 1'b1) : BIN_W'(number);

	// several shift-add-3 iterations per cycle
	always_comb begin
		logic [BCD_W-1:0] b;
		logic [BIN_W-1:0] m;
		b = bcd_q;
		m = mag_q;
		for (int s = 0; s < BITS_PER_STEP; s++) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				if (b[4*d +: 4] >= 4'd5) begin
					b[4*d +: 4] = b[4*d +: 4] + 4'd3;
				end
			end
			b = {b[BCD_W-2:0], m[BIN_W-1]};
			m = {m[BIN_W-2:0], 1'b0};
		end
		bcd_nx = b;
		mag_nx = m;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= mag_in;
			bcd_q <= '0;
			cnt_q <= '0;
			dig_q <= DIG_CNT_W'(NUM_DIGITS);
			neg_q <= number[BIN_W-1];
		end else if (cmd.step) begin
			mag_q <= mag_nx;
			bcd_q <= bcd_nx;
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'h0};
			dig_q <= dig_q - 1'b1;
		end
	end

	assign top = bcd_q[BCD_W-1 -: 4];

	assign status.step_last = (cnt_q == STEP_CNT_W'(NUM_STEPS - 1));
	assign status.top_zero  = (top == 4'h0);
	assign status.dig_one   = (dig_q == DIG_CNT_W'(1));
	assign status.negative  = neg_q;

	assign char_code = cmd.sign ? ASCII_MINUS : 8'(ASCII_ZERO + {4'h0, top});
	assign last_char = !cmd.sign && status.dig_one;

endmodule

`default_nettype wire

// ===== rtl/sitad_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitad_ctrl
// Sequencer: load, convert, drop leading zeros, then hand out characters.
// ----------------------------------------------------------------------------
`default_nettype none

module sitad_ctrl
	import sitad_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	output logic         out_valid,
	input  wire logic    out_stall,
	input  wire status_t status,
	output cmd_t         cmd
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_nx = S_CONV;
			end
			S_CONV: begin
				if (status.step_last) state_nx = S_SKIP;
			end
			S_SKIP: begin
				if (!(status.top_zero && !status.dig_one)) begin
					state_nx = status.negative ? S_SIGN : S_DIGIT;
				end
			end
			S_SIGN: begin
				if (!out_stall) state_nx = S_DIGIT;
			end
			S_DIGIT: begin
				if (!out_stall && status.dig_one) state_nx = S_IDLE;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_CONV: begin
				cmd.step = 1'b1;
			end
			S_SKIP: begin
				cmd.shift = status.top_zero && !status.dig_one;
			end
			S_SIGN: begin
				out_valid = 1'b1;
				cmd.sign  = 1'b1;
			end
			S_DIGIT: begin
				out_valid = 1'b1;
				cmd.shift = !out_stall && !status.dig_one;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/sitad_checker.sv =====
// ----------------------------------------------------------------------------
// sitad_checker
// Port-level checks for the signed integer to ASCII decimal block.
// ----------------------------------------------------------------------------
`default_nettype none

module sitad_checker
	import sitad_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_stall,
	input wire logic signed [BIN_W-1:0] number,
	input wire logic                    out_valid,
	input wire logic                    out_stall,
	input wire logic [7:0]              char_code,
	input wire logic                    last_char
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char))
		else $error("stalled output item changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && !out_valid)
		else $error("block not busy after taking a number");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> char_code == ASCII_MINUS ||
			(char_code >= ASCII_ZERO && char_code <= ASCII_NINE))
		else $error("character outside minus sign and digits");

	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_code == ASCII_MINUS |-> !last_char)
		else $error("minus sign flagged as last character");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_char |=> !out_valid && !in_stall)
		else $error("no return to idle after last character");

endmodule

bind signed_int_to_ascii_decimal sitad_checker u_sitad_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for signed_int_to_ascii_decimal: numbers go in through
// a queue-fed driver, a clocked monitor spells each accepted number out in
// decimal and checks every character leaving the block against that text.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import sitad_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [BIN_W-1:0] value;
		bit                      drain_first;
		bit                      steady;
	} number_item_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} glyph_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [BIN_W-1:0] number = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [7:0]              char_code;
	logic                    last_char;

	number_item_t numbers_to_send[$];
	glyph_t       pending_glyphs[$];
	bit           in_taken = 1'b0;
	int           numbers_taken = 0;
	int           negatives_taken = 0;
	int           glyphs_seen = 0;
	int           mismatches = 0;

	signed_int_to_ascii_decimal uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.number    (number),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// decimal text of one number, most significant digit first
	function automatic void spell_decimal(input logic signed [BIN_W-1:0] value);
		logic [BIN_W-1:0] magnitude;
		logic [3:0]       digits [NUM_DIGITS];
		int               count;
		glyph_t           g;
		magnitude = value[BIN_W-1] ? (~value + 1'b1) : value;
		count = 0;
		do begin
			digits[count] = 4'(magnitude % 10);
			magnitude = magnitude / 10;
			count++;
		end while (magnitude != 0 && count < NUM_DIGITS);
		if (value[BIN_W-1]) begin
			g.code = ASCII_MINUS;
			g.last = 1'b0;
			pending_glyphs.push_back(g);
		end
		for (int i = count - 1; i >= 0; i--) begin
			g.code = ASCII_ZERO + 8'(digits[i]);
			g.last = (i == 0);
			pending_glyphs.push_back(g);
		end
	endfunction

	task automatic queue_number(input logic signed [BIN_W-1:0] value, input bit drain_first,
			input bit steady);
		number_item_t item;
		item.value = value;
		item.drain_first = drain_first;
		item.steady = steady;
		numbers_to_send.push_back(item);
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (numbers_to_send.size() != 0
					&& !(numbers_to_send[0].drain_first
						&& (pending_glyphs.size() != 0 || in_valid))
					&& (numbers_to_send[0].steady || $urandom_range(99) >= 11)) begin
				in_valid <= 1'b1;
				number <= numbers_to_send[0].value;
				void'(numbers_to_send.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, quiet over a long stretch
	always @(negedge clk) begin
		out_stall <= arst_n && !(glyphs_seen >= 600 && glyphs_seen < 1300)
			&& ($urandom_range(99) < 11);
	end

	// monitor
	always @(posedge clk) begin
		glyph_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				glyphs_seen++;
				if (pending_glyphs.size() == 0) begin
					$error("char_code %0d (last_char %0b) with no character expected",
						char_code, last_char);
					mismatches++;
				end else begin
					want = pending_glyphs.pop_front();
					if (char_code !== want.code) begin
						$error("char_code: expected %0d, got %0d", want.code, char_code);
						mismatches++;
					end
					if (last_char !== want.last) begin
						$error("last_char: expected %0b, got %0b", want.last, last_char);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				spell_decimal(number);
				numbers_taken++;
				if (number < 0)
					negatives_taken++;
			end
		end
		in_taken <= arst_n && in_valid && !in_stall;
	end

	initial begin
		logic signed [BIN_W-1:0] directed [22];
		logic signed [BIN_W-1:0] value;
		int unsigned             bound;
		int unsigned             width;

		directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647, -2147483648,
			-2147483647, 1000000000, 999999999, -999999999, 1234567890, -1234567890,
			32'sh5555_5555, 32'shAAAA_AAAA, 1000000, -7};
		foreach (directed[i])
			queue_number(directed[i], i == 12, 1'b0);

		for (int n = 0; n < 430; n++) begin
			width = $urandom_range(1, 10);
			if (width == 10) begin
				value = $urandom();
			end else begin
				bound = 1;
				repeat (width) bound = bound * 10;
				value = $urandom_range(0, bound - 1);
				if ($urandom_range(1))
					value = -value;
			end
			queue_number(value, n == 100 || n == 300, n >= 150 && n < 240);
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (numbers_to_send.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_glyphs.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d numbers rendered (%0d negative), %0d characters checked",
			numbers_taken, negatives_taken, glyphs_seen);
		$display("both channels stalled at random, with quiet stretches and a full drain");
		if (mismatches == 0 && pending_glyphs.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timed out with %0d characters outstanding", pending_glyphs.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sitad_pkg.sv
rtl/sitad_datapath.sv
rtl/sitad_ctrl.sv
rtl/signed_int_to_ascii_decimal.sv
rtl/sitad_checker.sv
verif/tb.sv
